FILE: rtl/core/tpsp_pkg.sv
// ----------------------------------------------------------------------------
// tpsp_pkg
// Types and constants shared by the command stream parser modules.
// ----------------------------------------------------------------------------
package tpsp_pkg;

    localparam int CONTEXT_WORDS = 65536;
    localparam int CTX_CNT_W     = $clog2(CONTEXT_WORDS + 1);
    localparam int QUEUE_DEPTH   = 2;
    localparam int OUT_DATA_W    = 24;

    // parameter types
    localparam logic [2:0] PARA_END_LIST  = 3'd0;
    localparam logic [2:0] PARA_TILE_CLIP = 3'd1;
    localparam logic [2:0] PARA_OBJ_SET   = 3'd2;
    localparam logic [2:0] PARA_POLY      = 3'd4;
    localparam logic [2:0] PARA_SPRITE    = 3'd5;
    localparam logic [2:0] PARA_VERTEX    = 3'd7;

    localparam logic [2:0] LIST_OP_MODVOL = 3'd1;
    localparam logic [2:0] LIST_TR_MODVOL = 3'd3;
    localparam logic [2:0] LIST_LAST      = 3'd4;

    localparam logic [2:0] ERR_OK        = 3'd0;
    localparam logic [2:0] ERR_INVALID   = 3'd1;
    localparam logic [2:0] ERR_OBJ_SET   = 3'd2;
    localparam logic [2:0] ERR_OVERFLOW  = 3'd3;
    localparam logic [2:0] ERR_BAD_LIST  = 3'd4;

    // how the command length follows from a control word
    typedef enum logic [1:0] {
        LEN_SHORT,
        LEN_LONG,
        LEN_VERTEX,
        LEN_INVALID
    } t_len;

    // control word decoded ahead of the state update
    typedef struct packed {
        logic [2:0] para;
        logic [2:0] list;
        logic [2:0] poly;
        logic [4:0] vert;
        t_len       len;
    } t_info;

    typedef struct packed {
        logic  init;
        t_info info;
    } t_item;

    localparam t_info INFO_ZERO = '{
        para: 3'd0, list: 3'd0, poly: 3'd0, vert: 5'd0, len: LEN_SHORT
    };

endpackage

FILE: rtl/core/tpsp_front.sv
// ----------------------------------------------------------------------------
// tpsp_front
// Classifies an incoming word as a control word: parameter, list, poly and
// vertex type and the rule for the command length.
// ----------------------------------------------------------------------------
module tpsp_front (
    input  logic            i_init,
    input  logic [31:0]     i_word,
    output tpsp_pkg::t_item o_item
);
    import tpsp_pkg::*;

    function automatic logic [2:0] poly_of(input logic [31:0] w, input logic [2:0] list,
                                           input logic [2:0] para);
        logic [1:0] col;
        logic [2:0] res;
        begin
            col = w[5:4];
            if (list == LIST_OP_MODVOL || list == LIST_TR_MODVOL) begin
                res = 3'd6;
            end else if (para == PARA_SPRITE) begin
                res = 3'd5;
            end else if (w[6]) begin
                if (col == 2'd0 || col == 2'd3) res = 3'd3;
                else if (col == 2'd2)           res = 3'd4;
                else                            res = 3'd0;
            end else if (col != 2'd2) begin
                res = 3'd0;
            end else begin
                res = (w[3] && w[2]) ? 3'd2 : 3'd1;
            end
            return res;
        end
    endfunction

    function automatic logic [4:0] vert_of(input logic [31:0] w);
        logic [1:0] col;
        logic [4:0] res;
        begin
            col = w[5:4];
            if (w[26:24] == LIST_OP_MODVOL || w[26:24] == LIST_TR_MODVOL) begin
                res = 5'd17;
            end else if (w[31:29] == PARA_SPRITE) begin
                res = w[3] ? 5'd16 : 5'd15;
            end else if (w[6]) begin
                if (w[3]) begin
                    if (col == 2'd0)      res = w[0] ? 5'd12 : 5'd11;
                    else if (col[1])      res = w[0] ? 5'd14 : 5'd13;
                    else                  res = 5'd0;
                end else begin
                    if (col == 2'd0)      res = 5'd9;
                    else if (col[1])      res = 5'd10;
                    else                  res = 5'd0;
                end
            end else if (w[3]) begin
                if (col == 2'd0)          res = w[0] ? 5'd4 : 5'd3;
                else if (col == 2'd1)     res = w[0] ? 5'd6 : 5'd5;
                else                      res = w[0] ? 5'd8 : 5'd7;
            end else begin
                res = col[1] ? 5'd2 : {3'd0, col};
            end
            return res;
        end
    endfunction

    logic [2:0] para;
    logic [2:0] list;
    logic [2:0] poly_len;
    t_len       len;

    assign para = i_word[31:29];
    assign list = i_word[26:24];

    // length of a poly command is taken with the list as opaque
    assign poly_len = poly_of({24'd0, i_word[7:0]}, 3'd0, 3'd0);

    always_comb begin
        case (para)
            PARA_END_LIST, PARA_TILE_CLIP, PARA_OBJ_SET, PARA_SPRITE: len = LEN_SHORT;
            PARA_POLY: len = (poly_len == 3'd0 || poly_len == 3'd1 || poly_len == 3'd3)
                             ? LEN_SHORT : LEN_LONG;
            PARA_VERTEX: len = LEN_VERTEX;
            default: len = LEN_INVALID;
        endcase
    end

    always_comb begin
        o_item.init      = i_init;
        o_item.info.para = para;
        o_item.info.list = list;
        o_item.info.poly = (para == PARA_POLY || para == PARA_SPRITE)
                           ? poly_of(i_word, list, para) : 3'd0;
        o_item.info.vert = vert_of(i_word);
        o_item.info.len  = len;
    end

endmodule

FILE: rtl/core/tpsp_queue.sv
// ----------------------------------------------------------------------------
// tpsp_queue
// Short queue of classified words between the front and the back end.
// ----------------------------------------------------------------------------
module tpsp_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  tpsp_pkg::t_item i_item,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_empty,
    output tpsp_pkg::t_item o_item
);
    import tpsp_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_item            r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wptr, n_wptr;
    logic [PTR_W-1:0] r_rptr, n_rptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_item  = r_mem[r_rptr];

    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (do_push) begin
            n_wptr = (r_wptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (do_pop) begin
            n_rptr = (r_rptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        if (do_push && !do_pop) n_count = r_count + 1'b1;
        else if (do_pop && !do_push) n_count = r_count - 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wptr] <= i_item;
    end

endmodule

FILE: rtl/core/tpsp_back.sv
// ----------------------------------------------------------------------------
// tpsp_back
// Parse state update: command framing, list and vertex type tracking,
// end-of-list and error reporting, with the result register.
// ----------------------------------------------------------------------------
module tpsp_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_empty,
    input  tpsp_pkg::t_item i_item,
    output logic            o_pop,
    output logic            o_valid,
    input  logic            i_ready,
    output logic            o_done,
    output logic [2:0]      o_para,
    output logic            o_long,
    output logic [2:0]      o_poly,
    output logic [4:0]      o_vert,
    output logic            o_irq,
    output logic [2:0]      o_irq_list,
    output logic [2:0]      o_err
);
    import tpsp_pkg::*;

    t_info                r_hdr, n_hdr;
    logic [3:0]           r_wic, n_wic;
    logic [CTX_CNT_W-1:0] r_words, n_words;
    logic [2:0]           r_list, n_list;
    logic [4:0]           r_vk, n_vk;
    logic                 r_valid;

    logic                 r_done, n_done;
    logic [2:0]           r_para, n_para;
    logic                 r_long, n_long;
    logic [2:0]           r_poly, n_poly;
    logic                 r_irq, n_irq;
    logic [2:0]           r_irq_list, n_irq_list;
    logic [2:0]           r_err, n_err;

    t_info                cur;
    logic                 vk_short;
    logic                 is_long;
    logic                 is_bad;
    logic                 overflow;

    assign o_pop = !i_empty && (!r_valid || i_ready);

    assign overflow = (r_words >= CTX_CNT_W'(CONTEXT_WORDS));

    // control word in force for this transfer
    always_comb begin
        if (i_item.init) cur = INFO_ZERO;
        else if (!overflow && r_wic == 4'd0) cur = i_item.info;
        else cur = r_hdr;
    end

    // vertex length uses the vertex type from before this word
    assign vk_short = (r_vk <= 5'd4) || (r_vk >= 5'd7 && r_vk <= 5'd10);
    assign is_long  = (cur.len == LEN_LONG) || (cur.len == LEN_VERTEX && !vk_short);
    assign is_bad   = (cur.len == LEN_INVALID);

    always_comb begin
        n_hdr      = r_hdr;
        n_wic      = r_wic;
        n_words    = r_words;
        n_list     = r_list;
        n_vk       = r_vk;
        n_done     = 1'b0;
        n_irq      = 1'b0;
        n_irq_list = 3'd0;
        n_err      = ERR_OK;
        if (i_item.init) begin
            n_hdr   = INFO_ZERO;
            n_wic   = 4'd0;
            n_words = '0;
            n_list  = 3'd0;
            n_vk    = 5'd0;
        end else if (overflow) begin
            n_err = ERR_OVERFLOW;
        end else begin
            n_hdr   = cur;
            n_words = r_words + 1'b1;
            if ((r_wic == 4'd7 && !is_long) || r_wic == 4'd15) begin
                n_done = 1'b1;
                n_wic  = 4'd0;
                if (is_bad) begin
                    n_err = ERR_INVALID;
                end else if (cur.para == PARA_END_LIST) begin
                    if (r_list <= LIST_LAST) begin
                        n_irq      = 1'b1;
                        n_irq_list = r_list;
                    end else begin
                        n_err = ERR_BAD_LIST;
                    end
                    n_list = 3'd0;
                    n_vk   = 5'd0;
                end else if (cur.para == PARA_OBJ_SET) begin
                    n_err = ERR_OBJ_SET;
                end else if (cur.para == PARA_POLY || cur.para == PARA_SPRITE) begin
                    if (cur.list > LIST_LAST) begin
                        n_err = ERR_BAD_LIST;
                    end else begin
                        n_list = cur.list;
                        n_vk   = cur.vert;
                    end
                end
            end else begin
                n_wic = r_wic + 1'b1;
            end
        end
        n_para = cur.para;
        n_long = is_long;
        n_poly = cur.poly;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr   <= INFO_ZERO;
            r_wic   <= 4'd0;
            r_words <= '0;
            r_list  <= 3'd0;
            r_vk    <= 5'd0;
            r_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_hdr   <= n_hdr;
                r_wic   <= n_wic;
                r_words <= n_words;
                r_list  <= n_list;
                r_vk    <= n_vk;
            end
            if (o_pop) r_valid <= 1'b1;
            else if (i_ready) r_valid <= 1'b0;
        end
    end

    // result register, no reset needed on payload
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_done     <= n_done;
            r_para     <= n_para;
            r_long     <= n_long;
            r_poly     <= n_poly;
            r_irq      <= n_irq;
            r_irq_list <= n_irq_list;
            r_err      <= n_err;
        end
    end

    assign o_valid    = r_valid;
    assign o_done     = r_done;
    assign o_para     = r_para;
    assign o_long     = r_long;
    assign o_poly     = r_poly;
    assign o_vert     = r_vk;
    assign o_irq      = r_irq;
    assign o_irq_list = r_irq_list;
    assign o_err      = r_err;

endmodule

FILE: rtl/core/tile_param_stream_parser_top.sv
// ----------------------------------------------------------------------------
// tile_param_stream_parser_top
// Command stream parser for a tile accelerator.
// ----------------------------------------------------------------------------
// Usage:
// Slave stream takes one 32-bit command word per transfer on s_axis_tdata;
// s_axis_tuser high makes the transfer an init request that clears the parse
// state (the data word is then ignored). Every input transfer gives exactly
// one result transfer on the master stream, in order. m_axis_tlast marks the
// word that completes a command; m_axis_tdata carries types, end-of-list
// flag and error code.
// Result valid rises once the input word has been written into the
// classification queue and the state update has then loaded the result
// register.
// Throughput is one word per cycle while the receiver does not stall, set by
// the state update in the back end.
// After reset the parse state, queue and result register are empty.
// When the receiver stalls, the result is held and the two-entry queue
// absorbs further words; s_axis_tready drops once the queue is full.
// ----------------------------------------------------------------------------
module tile_param_stream_parser_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] cmd_word
    input  logic [0:0]  s_axis_tuser,   // [0] req_type
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [2:0] para_kind, [3] cmd_long, [6:4] poly_kind, [11:7] vert_kind,
    // [12] list_end_irq, [15:13] irq_list, [18:16] error_code, [23:19] zero
    output logic [tpsp_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    output logic        m_axis_tlast    // cmd_done
);
    import tpsp_pkg::*;

    t_item      front_item;
    t_item      queue_item;
    logic       queue_full;
    logic       queue_empty;
    logic       queue_pop;
    logic       in_xfer;

    logic [2:0] para;
    logic       cmd_long;
    logic [2:0] poly;
    logic [4:0] vert;
    logic       irq;
    logic [2:0] irq_list;
    logic [2:0] err;

    assign s_axis_tready = !queue_full;
    assign in_xfer       = s_axis_tvalid && !queue_full;

    tpsp_front u_front (
        .i_init (s_axis_tuser[0]),
        .i_word (s_axis_tdata),
        .o_item (front_item)
    );

    tpsp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (in_xfer),
        .i_item  (front_item),
        .o_full  (queue_full),
        .i_pop   (queue_pop),
        .o_empty (queue_empty),
        .o_item  (queue_item)
    );

    tpsp_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_empty    (queue_empty),
        .i_item     (queue_item),
        .o_pop      (queue_pop),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_done     (m_axis_tlast),
        .o_para     (para),
        .o_long     (cmd_long),
        .o_poly     (poly),
        .o_vert     (vert),
        .o_irq      (irq),
        .o_irq_list (irq_list),
        .o_err      (err)
    );

    assign m_axis_tdata = {5'd0, err, irq_list, irq, vert, poly, cmd_long, para};

endmodule
